// ===== hdl/clst_pkg.sv =====
// Shared types and constants for the character list store.
// No dependencies; imported by every module of the block.
package clst_pkg;

    localparam int DEPTH_DEF = 32;
    localparam int CHAR_W    = 8;
    localparam int CMD_W     = 3;
    localparam int STAT_W    = 2;
    localparam int LEN_W     = 6;
    localparam int S_DATA_W  = 16;
    localparam int M_DATA_W  = 24;

    typedef enum logic [CMD_W-1:0] {
        CMD_ADD      = 3'd0,
        CMD_REMOVE   = 3'd1,
        CMD_DUMP_FWD = 3'd2,
        CMD_DUMP_BWD = 3'd3,
        CMD_CLEAR    = 3'd4
    } cmd_t;

    typedef enum logic [STAT_W-1:0] {
        ST_OK        = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_FULL      = 2'd2,
        ST_EMPTY     = 2'd3
    } stat_t;

    typedef enum logic [2:0] {
        CM_HOLD,
        CM_SHIFT_R,
        CM_SHIFT_L,
        CM_MARK,
        CM_SORT
    } cell_mode_t;

    typedef struct packed {
        cell_mode_t        mode;
        logic              phase;
        logic [CHAR_W-1:0] ch;
    } cell_ctrl_t;

endpackage

// ===== hdl/char_list_store_top.sv =====
// Top level of the character list store: command decode, sequencer, result register.
// Depends on clst_pkg and clst_cell.
//
// Holds up to DEPTH characters in a row of cells, front at cell 0. A request is taken
// only while the block is idle. Add and clear post their result straight from decode.
// Remove marks all cells at once, then compacts the survivors with DEPTH odd-even swap
// passes along the chain while counting them, and posts its result. Dumps rotate the
// chain through one full turn of DEPTH steps, emitting one character per step while the
// entries pass the output end; a step waits while the result side stalls. A dump of an
// empty store posts a single result.
module char_list_store_top
    import clst_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_axis_tvalid,
    output logic                s_axis_tready,
    input  logic [S_DATA_W-1:0] s_axis_tdata,  // command[2:0], char_value[10:3]
    output logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    output logic [M_DATA_W-1:0] m_axis_tdata,  // char_out[7:0], status[9:8],
                                               // removed_count[15:10], length[21:16]
    output logic                m_axis_tlast
);

    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int IDX_W = $clog2(DEPTH);
    localparam int SUM_W = CNT_W + 1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_SORT,
        S_POST,
        S_DUMP
    } state_t;

    state_t            state_reg;
    cmd_t              cmd_reg;
    logic [CHAR_W-1:0] ch_reg;
    logic [CNT_W-1:0]  n_reg;
    logic [CNT_W-1:0]  keep_reg;
    logic [IDX_W-1:0]  k_reg;

    logic              out_valid_reg;
    logic [CHAR_W-1:0] out_char_reg;
    stat_t             out_stat_reg;
    logic [LEN_W-1:0]  out_rem_reg;
    logic [LEN_W-1:0]  out_len_reg;
    logic              out_last_reg;

    cell_ctrl_t        ctrl;
    logic [CHAR_W-1:0] cell_data [DEPTH];
    logic [DEPTH-1:0]  cell_live;
    logic [DEPTH-1:0]  cell_tally;
    logic [CHAR_W-1:0] head_left;

    logic s_accept;
    logic out_free;
    logic out_load;
    logic fwd;
    logic emit;
    logic step_ok;
    logic full;
    logic k_end;
    logic [CNT_W-1:0] removed;

    assign s_accept = s_axis_tvalid && s_axis_tready;
    assign out_free = !out_valid_reg || m_axis_tready;
    assign fwd      = (cmd_reg == CMD_DUMP_FWD);
    assign full     = (n_reg >= CNT_W'(DEPTH));
    assign k_end    = (k_reg == IDX_W'(DEPTH - 1));
    assign removed  = n_reg - keep_reg;
    assign emit     = (state_reg == S_DUMP) &&
                      (fwd ? (CNT_W'(k_reg) < n_reg)
                           : (SUM_W'(k_reg) + SUM_W'(n_reg) >= SUM_W'(DEPTH)));
    assign step_ok  = !emit || out_free;
    assign out_load = out_free &&
                      (emit ||
                       (state_reg == S_POST) ||
                       ((state_reg == S_DECODE) &&
                        ((cmd_reg == CMD_ADD) || (cmd_reg == CMD_CLEAR) ||
                         (((cmd_reg == CMD_DUMP_FWD) || (cmd_reg == CMD_DUMP_BWD)) &&
                          (n_reg == '0)))));

    always_comb begin
        ctrl.mode  = CM_HOLD;
        ctrl.phase = k_reg[0];
        ctrl.ch    = ch_reg;
        unique case (state_reg)
            S_DECODE: begin
                if (cmd_reg == CMD_ADD && !full && out_free) begin
                    ctrl.mode = CM_SHIFT_R;
                end else if (cmd_reg == CMD_REMOVE) begin
                    ctrl.mode = CM_MARK;
                end
            end
            S_SORT: begin
                ctrl.mode = CM_SORT;
            end
            S_DUMP: begin
                if (step_ok) begin
                    ctrl.mode = fwd ? CM_SHIFT_L : CM_SHIFT_R;
                end
            end
            default: begin
            end
        endcase
    end

    assign head_left = (state_reg == S_DECODE) ? ch_reg : cell_data[DEPTH-1];

    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
        logic [CHAR_W-1:0] l_data, r_data;
        logic              l_live, r_live, r_tally;
        if (i == 0) begin : g_first
            assign l_data = head_left;
            assign l_live = 1'b1;
        end else begin : g_mid_l
            assign l_data = cell_data[i-1];
            assign l_live = cell_live[i-1];
        end
        if (i == DEPTH - 1) begin : g_last
            assign r_data  = cell_data[0];
            assign r_live  = 1'b0;
            assign r_tally = 1'b0;
        end else begin : g_mid_r
            assign r_data  = cell_data[i+1];
            assign r_live  = cell_live[i+1];
            assign r_tally = cell_tally[i+1];
        end
        clst_cell #(
            .INDEX (i),
            .CNT_W (CNT_W)
        ) u_cell (
            .aclk        (aclk),
            .ctrl        (ctrl),
            .n           (n_reg),
            .left_data   (l_data),
            .left_live   (l_live),
            .right_data  (r_data),
            .right_live  (r_live),
            .right_tally (r_tally),
            .data_o      (cell_data[i]),
            .live_o      (cell_live[i]),
            .tally_o     (cell_tally[i])
        );
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            n_reg         <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_load || (out_valid_reg && !m_axis_tready);
            unique case (state_reg)
                S_IDLE: begin
                    if (s_accept) begin
                        cmd_reg   <= cmd_t'(s_axis_tdata[CMD_W-1:0]);
                        ch_reg    <= s_axis_tdata[CMD_W +: CHAR_W];
                        state_reg <= S_DECODE;
                    end
                end
                S_DECODE: begin
                    k_reg    <= '0;
                    keep_reg <= '0;
                    unique case (cmd_reg)
                        CMD_ADD: begin
                            if (out_free) begin
                                out_char_reg  <= '0;
                                out_stat_reg  <= full ? ST_FULL : ST_OK;
                                out_rem_reg   <= '0;
                                out_len_reg   <= full ? LEN_W'(n_reg) : LEN_W'(n_reg + 1'b1);
                                out_last_reg  <= 1'b1;
                                if (!full) begin
                                    n_reg <= n_reg + 1'b1;
                                end
                                state_reg <= S_IDLE;
                            end
                        end
                        CMD_REMOVE: begin
                            state_reg <= S_SORT;
                        end
                        CMD_DUMP_FWD, CMD_DUMP_BWD: begin
                            if (n_reg != '0) begin
                                state_reg <= S_DUMP;
                            end else if (out_free) begin
                                out_char_reg  <= '0;
                                out_stat_reg  <= ST_EMPTY;
                                out_rem_reg   <= '0;
                                out_len_reg   <= '0;
                                out_last_reg  <= 1'b1;
                                state_reg     <= S_IDLE;
                            end
                        end
                        CMD_CLEAR: begin
                            if (out_free) begin
                                n_reg         <= '0;
                                out_char_reg  <= '0;
                                out_stat_reg  <= ST_OK;
                                out_rem_reg   <= '0;
                                out_len_reg   <= '0;
                                out_last_reg  <= 1'b1;
                                state_reg     <= S_IDLE;
                            end
                        end
                        default: begin
                            state_reg <= S_IDLE;
                        end
                    endcase
                end
                S_SORT: begin
                    keep_reg <= keep_reg + CNT_W'(cell_tally[0]);
                    k_reg    <= k_reg + 1'b1;
                    if (k_end) begin
                        state_reg <= S_POST;
                    end
                end
                S_POST: begin
                    if (out_free) begin
                        n_reg         <= keep_reg;
                        out_char_reg  <= '0;
                        out_stat_reg  <= (removed == '0) ? ST_NOT_FOUND : ST_OK;
                        out_rem_reg   <= LEN_W'(removed);
                        out_len_reg   <= LEN_W'(keep_reg);
                        out_last_reg  <= 1'b1;
                        state_reg     <= S_IDLE;
                    end
                end
                S_DUMP: begin
                    if (step_ok) begin
                        k_reg <= k_reg + 1'b1;
                        if (emit) begin
                            out_char_reg  <= fwd ? cell_data[0] : cell_data[DEPTH-1];
                            out_stat_reg  <= ST_OK;
                            out_rem_reg   <= '0;
                            out_len_reg   <= LEN_W'(n_reg);
                            out_last_reg  <= fwd ? (CNT_W'(k_reg) + 1'b1 == n_reg) : k_end;
                        end
                        if (k_end) begin
                            state_reg <= S_IDLE;
                        end
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign s_axis_tready = (state_reg == S_IDLE);
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {2'b00, out_len_reg, out_rem_reg, out_stat_reg, out_char_reg};
    assign m_axis_tlast  = out_last_reg;

endmodule

// ===== hdl/clst_cell.sv =====
// One storage cell of the list chain: a character plus live/tally flags.
// Depends on clst_pkg; instantiated in a row by char_list_store_top.
module clst_cell
    import clst_pkg::*;
#(
    parameter int INDEX = 0,
    parameter int CNT_W = 6
) (
    input  logic              aclk,
    input  cell_ctrl_t        ctrl,
    input  logic [CNT_W-1:0]  n,
    input  logic [CHAR_W-1:0] left_data,
    input  logic              left_live,
    input  logic [CHAR_W-1:0] right_data,
    input  logic              right_live,
    input  logic              right_tally,
    output logic [CHAR_W-1:0] data_o,
    output logic              live_o,
    output logic              tally_o
);

    localparam logic PAR = 1'(INDEX % 2);

    logic [CHAR_W-1:0] data_reg, data_next;
    logic              live_reg, live_next;
    logic              tally_reg, tally_next;
    logic              keep;
    logic              pair_right;

    assign keep       = (CNT_W'(INDEX) < n) && (data_reg != ctrl.ch);
    assign pair_right = (ctrl.phase == PAR);

    always_comb begin
        data_next  = data_reg;
        live_next  = live_reg;
        tally_next = tally_reg;
        unique case (ctrl.mode)
            CM_HOLD: begin
            end
            CM_SHIFT_R: begin
                data_next = left_data;
            end
            CM_SHIFT_L: begin
                data_next = right_data;
            end
            CM_MARK: begin
                live_next  = keep;
                tally_next = keep;
            end
            CM_SORT: begin
                tally_next = right_tally;
                // odd-even transposition: a dead cell trades with a live right neighbor
                if (pair_right && !live_reg && right_live) begin
                    data_next = right_data;
                    live_next = 1'b1;
                end else if (!pair_right && !left_live && live_reg) begin
                    data_next = left_data;
                    live_next = 1'b0;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        data_reg  <= data_next;
        live_reg  <= live_next;
        tally_reg <= tally_next;
    end

    assign data_o  = data_reg;
    assign live_o  = live_reg;
    assign tally_o = tally_reg;

endmodule

// ===== hdl/clst_checker.sv =====
// Port-level checks for the character list store, bound to the top level.
// Depends on clst_pkg and char_list_store_top.
module clst_checker
    import clst_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
) (
    input logic                aclk,
    input logic                aresetn,
    input logic                s_axis_tvalid,
    input logic                s_axis_tready,
    input logic [S_DATA_W-1:0] s_axis_tdata,
    input logic                m_axis_tvalid,
    input logic                m_axis_tready,
    input logic [M_DATA_W-1:0] m_axis_tdata,
    input logic                m_axis_tlast
);

    localparam logic [LEN_W-1:0] FULL_LEN = LEN_W'(DEPTH);

    logic [STAT_W-1:0] stat;
    logic [LEN_W-1:0]  rem;
    logic [LEN_W-1:0]  len;

    assign stat = m_axis_tdata[CHAR_W +: STAT_W];
    assign rem  = m_axis_tdata[CHAR_W + STAT_W +: LEN_W];
    assign len  = m_axis_tdata[CHAR_W + STAT_W + LEN_W +: LEN_W];

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
        else $error("result changed while stalled");

    a_busy_after_req: assert property (@(posedge aclk) disable iff (!aresetn)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("request taken while previous one still in work");

    a_full_len: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && stat == ST_FULL |-> len == FULL_LEN && m_axis_tlast)
        else $error("full report with wrong length");

    a_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && stat == ST_EMPTY |->
            len == '0 && m_axis_tlast && m_axis_tdata[CHAR_W-1:0] == '0)
        else $error("empty report malformed");

    a_not_found: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && stat == ST_NOT_FOUND |-> rem == '0 && m_axis_tlast)
        else $error("not-found report with nonzero count");

endmodule

bind char_list_store_top clst_checker #(.DEPTH(DEPTH)) u_clst_checker (.*);
